@@ rtl/spi_nor_flash_command_sequencer_top_macros.svh @@
// Assertion macros for the flash command sequencer.
// Used by the top level only.
`ifndef SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define SPI_NOR_FLASH_COMMAND_SEQUENCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SNF_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SNF_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SNF_ASSERT_IMPL(lbl, clk, rst_n, a, c, msg)
`define SNF_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

@@ rtl/snf_pkg.sv @@
// Shared types and constants for the flash command sequencer.
// No dependencies.
`timescale 1ns / 1ps
package snf_pkg;
  localparam logic [2:0] FN_INIT = 3'd0;
  localparam logic [2:0] FN_READ = 3'd1;
  localparam logic [2:0] FN_PROG = 3'd2;
  localparam logic [2:0] FN_SE   = 3'd3;
  localparam logic [2:0] FN_BE   = 3'd4;
  localparam logic [2:0] FN_CE   = 3'd5;
  localparam logic [2:0] FN_ACK  = 3'd6;
  localparam logic [2:0] FN_LERR = 3'd7;

  localparam logic [1:0] K_TX   = 2'd0;
  localparam logic [1:0] K_RD   = 2'd1;
  localparam logic [1:0] K_DONE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_REJ  = 2'd1;
  localparam logic [1:0] ST_XFER = 2'd2;
  localparam logic [1:0] ST_ID   = 2'd3;

  localparam logic [7:0] OP_ID   = 8'h90;
  localparam logic [7:0] OP_UID  = 8'h4B;
  localparam logic [7:0] OP_WREN = 8'h06;
  localparam logic [7:0] OP_RDSR = 8'h05;
  localparam logic [7:0] OP_READ = 8'h0B;
  localparam logic [7:0] OP_PROG = 8'h02;
  localparam logic [7:0] OP_SE   = 8'h20;
  localparam logic [7:0] OP_BE   = 8'hD8;
  localparam logic [7:0] OP_CE   = 8'hC7;
  localparam logic [7:0] MFR_ID  = 8'hEF;

  // classified request from front to back
  typedef struct packed {
    logic [2:0]  func;
    logic        reject;
    logic [25:0] address;
    logic [24:0] count;
    logic [7:0]  rx_byte;
    logic [7:0]  payload_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic        eof;
    logic [1:0]  status;
    logic [63:0] info;
    logic        last;
  } res_t;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b00000001,
    PH_ID    = 8'b00000010,
    PH_UID   = 8'b00000100,
    PH_WREN  = 8'b00001000,
    PH_CMD   = 8'b00010000,
    PH_DATA  = 8'b00100000,
    PH_POLLC = 8'b01000000,
    PH_POLLD = 8'b10000000
  } phase_t;
endpackage

@@ rtl/snf_front.sv @@
// Front end: registers each beat and precomputes bounds checks and clipping.
// Depends on snf_pkg.
`timescale 1ns / 1ps
module snf_front import snf_pkg::*; #(
  parameter int PAGE_BYTES  = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [25:0] in_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_payload_byte,
  input  logic [26:0] capacity,
  output logic        q_valid,
  input  logic        q_ready,
  output req_t        q_data
);
  localparam int PB = $clog2(PAGE_BYTES);
  localparam int LB = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
  logic        v_r;
  req_t        d_r, d_nxt;
  logic [26:0] len;
  logic [27:0] sum;
  logic [PB:0] room;

  assign in_ready = !v_r || q_ready;
  assign q_valid  = v_r;
  assign q_data   = d_r;

  always_comb begin
    len = 27'(in_length[LB-1:0]);
    sum = 28'(in_address) + 28'(len);
    room = (PB+1)'(PAGE_BYTES) - (PB+1)'(in_address[PB-1:0]);
    d_nxt.func = in_func;
    d_nxt.address = in_address;
    d_nxt.rx_byte = in_rx_byte;
    d_nxt.payload_byte = in_payload_byte;
    d_nxt.count = 25'(len);
    d_nxt.reject = 1'b0;
    if (in_func == FN_READ || in_func == FN_PROG) begin
      d_nxt.reject = (len == '0) || (sum > 28'(capacity));
      if (in_func == FN_PROG && len > 27'(room)) d_nxt.count = 25'(room);
    end else if (in_func == FN_SE || in_func == FN_BE) begin
      d_nxt.reject = 27'(in_address) >= capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) d_r <= d_nxt;
  end
endmodule

@@ rtl/snf_back.sv @@
// Back end: phase sequencer that issues bytes, read data and done results.
// Depends on snf_pkg. Emits up to two results per item through a holding stage.
`timescale 1ns / 1ps
module snf_back import snf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  req_t        q_data,
  output logic [26:0] capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);
  phase_t      ph_r, ph_nxt;
  logic [7:0]  op_r, op_nxt;
  logic [25:0] adr_r, adr_nxt;
  logic [24:0] left_r, left_nxt;
  logic [3:0]  fi_r, fi_nxt;
  logic [26:0] cap_r, cap_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [63:0] uid_r, uid_nxt;
  logic [7:0]  mfr_r, mfr_nxt;

  res_t        buf_r [3];
  res_t        ob    [3];
  logic [1:0]  cnt_r, rd_r, n;
  logic [3:0]  hl, i;
  logic        hd;
  logic [7:0]  hb;

  assign capacity  = cap_r;
  // next beat may enter as the last held result leaves
  assign q_ready   = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = buf_r[rd_r];

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] v, input logic e,
                              input logic [1:0] s, input logic [63:0] inf);
    res_t r;
    r.kind = k; r.value = v; r.eof = e; r.status = s; r.info = inf; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    ph_nxt = ph_r; op_nxt = op_r; adr_nxt = adr_r; left_nxt = left_r; fi_nxt = fi_r;
    cap_nxt = cap_r; dev_nxt = dev_r; uid_nxt = uid_r; mfr_nxt = mfr_r;
    n = 2'd0;
    for (int k = 0; k < 3; k++) ob[k] = mk(K_TX, 8'd0, 1'b0, ST_OK, 64'd0);
    hl = (op_r == OP_READ) ? 4'd5 : ((op_r == OP_CE) ? 4'd1 : 4'd4);
    hd = (op_r == OP_READ) || (op_r == OP_PROG);
    i  = fi_r - 4'd1;
    unique case (fi_r[1:0])
      2'd0: hb = op_r;
      2'd1: hb = adr_r[23:16];
      2'd2: hb = adr_r[15:8];
      default: hb = adr_r[7:0];
    endcase
    if (fi_r > 4'd3) hb = 8'd0;
    if (q_valid && q_ready) begin
      if (q_data.func == FN_ACK || q_data.func == FN_LERR) begin
        if (ph_r != PH_IDLE) begin
          if (q_data.func == FN_LERR) begin
            ob[0] = mk(K_DONE, 8'd0, 1'b0, (ph_r == PH_WREN) ? ST_REJ : ST_XFER, 64'd0);
            n = 2'd1; ph_nxt = PH_IDLE; fi_nxt = '0; left_nxt = '0;
          end else begin
            unique case (ph_r)
              PH_ID: begin
                if (i == 4'd4) mfr_nxt = q_data.rx_byte;
                if (i >= 4'd5) begin
                  dev_nxt = q_data.rx_byte;
                  if (mfr_r != MFR_ID || q_data.rx_byte < 8'h14 || q_data.rx_byte > 8'h19) begin
                    ob[0] = mk(K_DONE, q_data.rx_byte, 1'b0, ST_ID, 64'd0);
                    n = 2'd1; ph_nxt = PH_IDLE; fi_nxt = '0; left_nxt = '0;
                  end else begin
                    cap_nxt = 27'h200000 << (q_data.rx_byte[2:0] - 3'd4);
                    op_nxt = OP_UID; ph_nxt = PH_UID; uid_nxt = '0;
                    ob[0] = mk(K_TX, OP_UID, 1'b0, ST_OK, 64'd0);
                    n = 2'd1; fi_nxt = 4'd1;
                  end
                end else begin
                  ob[0] = mk(K_TX, 8'd0, fi_r == 4'd5, ST_OK, 64'd0);
                  n = 2'd1; fi_nxt = fi_r + 4'd1;
                end
              end
              PH_UID: begin
                if (i >= 4'd5) uid_nxt = {uid_r[55:0], q_data.rx_byte};
                if (i >= 4'd12) begin
                  ob[0] = mk(K_DONE, dev_r, 1'b0, ST_OK, uid_nxt);
                  n = 2'd1; ph_nxt = PH_IDLE; fi_nxt = '0; left_nxt = '0;
                end else begin
                  ob[0] = mk(K_TX, 8'd0, fi_r == 4'd12, ST_OK, 64'd0);
                  n = 2'd1; fi_nxt = fi_r + 4'd1;
                end
              end
              PH_WREN: begin
                ph_nxt = PH_CMD;
                ob[0] = mk(K_TX, op_r, (hl == 4'd1) && !hd, ST_OK, 64'd0);
                n = 2'd1; fi_nxt = 4'd1;
              end
              PH_CMD: begin
                n = 2'd1;
                if (fi_r < hl) begin
                  ob[0] = mk(K_TX, hb, (fi_r + 4'd1 == hl) && !hd, ST_OK, 64'd0);
                  fi_nxt = fi_r + 4'd1;
                end else if (hd) begin
                  ph_nxt = PH_DATA; left_nxt = left_r - 25'd1;
                  ob[0] = mk(K_TX, (op_r == OP_PROG) ? q_data.payload_byte : 8'd0,
                             left_r == 25'd1, ST_OK, 64'd0);
                end else begin
                  ph_nxt = PH_POLLC; ob[0] = mk(K_TX, OP_RDSR, 1'b0, ST_OK, 64'd0);
                end
              end
              PH_DATA: begin
                if (op_r == OP_READ) begin
                  ob[0] = mk(K_RD, q_data.rx_byte, 1'b0, ST_OK, 64'd0);
                  n = 2'd1;
                end
                if (left_r != '0) begin
                  left_nxt = left_r - 25'd1;
                  ob[n] = mk(K_TX, (op_r == OP_PROG) ? q_data.payload_byte : 8'd0,
                             left_r == 25'd1, ST_OK, 64'd0);
                end else if (op_r == OP_READ) begin
                  ob[n] = mk(K_DONE, 8'd0, 1'b0, ST_OK, 64'd0);
                  ph_nxt = PH_IDLE; fi_nxt = '0; left_nxt = '0;
                end else begin
                  ob[n] = mk(K_TX, OP_RDSR, 1'b0, ST_OK, 64'd0);
                  ph_nxt = PH_POLLC;
                end
                n = n + 2'd1;
              end
              PH_POLLC: begin
                ph_nxt = PH_POLLD; n = 2'd1;
                ob[0] = mk(K_TX, 8'd0, 1'b1, ST_OK, 64'd0);
              end
              PH_POLLD: begin
                n = 2'd1;
                if (q_data.rx_byte[0]) begin
                  ph_nxt = PH_POLLC; ob[0] = mk(K_TX, OP_RDSR, 1'b0, ST_OK, 64'd0);
                end else begin
                  ob[0] = mk(K_DONE, 8'd0, 1'b0, ST_OK, 64'd0);
                  ph_nxt = PH_IDLE; fi_nxt = '0; left_nxt = '0;
                end
              end
              default: ph_nxt = PH_IDLE;
            endcase
          end
        end
      end else if (ph_r == PH_IDLE) begin
        n = 2'd1;
        if (q_data.reject) begin
          ob[0] = mk(K_DONE, 8'd0, 1'b0, ST_REJ, 64'd0);
          fi_nxt = '0; left_nxt = '0;
        end else begin
          unique case (q_data.func)
            FN_INIT: begin
              op_nxt = OP_ID; ph_nxt = PH_ID; fi_nxt = 4'd1;
              ob[0] = mk(K_TX, OP_ID, 1'b0, ST_OK, 64'd0);
            end
            FN_READ: begin
              op_nxt = OP_READ; adr_nxt = q_data.address; left_nxt = q_data.count;
              ph_nxt = PH_CMD; fi_nxt = 4'd1;
              ob[0] = mk(K_TX, OP_READ, 1'b0, ST_OK, 64'd0);
            end
            default: begin
              ph_nxt = PH_WREN;
              ob[0] = mk(K_TX, OP_WREN, 1'b1, ST_OK, 64'd0);
              if (q_data.func == FN_PROG) begin
                op_nxt = OP_PROG; adr_nxt = q_data.address; left_nxt = q_data.count;
              end else if (q_data.func == FN_SE) begin
                op_nxt = OP_SE; adr_nxt = {q_data.address[25:12], 12'd0};
              end else if (q_data.func == FN_BE) begin
                op_nxt = OP_BE; adr_nxt = {q_data.address[25:16], 16'd0};
              end else begin
                op_nxt = OP_CE; adr_nxt = '0;
              end
            end
          endcase
        end
      end
      if (n != 2'd0) ob[n-2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; op_r <= '0; adr_r <= '0; left_r <= '0; fi_r <= '0;
      cap_r <= '0; dev_r <= '0; uid_r <= '0; mfr_r <= '0;
      cnt_r <= '0; rd_r <= '0;
    end else begin
      ph_r <= ph_nxt; op_r <= op_nxt; adr_r <= adr_nxt; left_r <= left_nxt;
      fi_r <= fi_nxt; cap_r <= cap_nxt; dev_r <= dev_nxt; uid_r <= uid_nxt;
      mfr_r <= mfr_nxt;
      if (q_valid && q_ready) begin
        cnt_r <= n; rd_r <= '0;
      end else if (out_valid && out_ready) begin
        cnt_r <= cnt_r - 2'd1; rd_r <= rd_r + 2'd1;
      end
    end
    if (q_valid && q_ready) begin
      for (int k = 0; k < 3; k++) buf_r[k] <= ob[k];
    end
  end
endmodule

@@ rtl/spi_nor_flash_command_sequencer_top.sv @@
// Serial NOR flash command sequencer: front classifier, one-entry queue, back sequencer.
// Path: front register, then back holding stage; up to 2 results per beat.
// Throughput: one beat per cycle when it gives no result, else one per result delivered
// (results leave one per cycle from the back holding stage while out_ready is high).
// Reset: synchronous active-low; idle, capacity zero: accesses but chip erase rejected.
`timescale 1ns / 1ps
`include "spi_nor_flash_command_sequencer_top_macros.svh"
module spi_nor_flash_command_sequencer_top import snf_pkg::*; #(
  parameter int PAGE_BYTES  = 256,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [25:0] in_address,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_rx_byte,
  input  logic [7:0]  in_payload_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_value,
  output logic        out_end_of_frame,
  output logic [1:0]  out_status,
  output logic [63:0] out_info,
  output logic        out_last
);
  logic        q_valid, q_ready;
  req_t        q_data;
  logic [26:0] capacity;
  res_t        res;

  snf_front #(.PAGE_BYTES(PAGE_BYTES), .LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_address, .in_length,
    .in_rx_byte, .in_payload_byte, .capacity, .q_valid, .q_ready, .q_data
  );

  snf_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .capacity,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_kind = res.kind;
  assign out_value = res.value;
  assign out_end_of_frame = res.eof;
  assign out_status = res.status;
  assign out_info = res.info;
  assign out_last = res.last;

  `SNF_ASSERT_IMPL(a_done_last, clk, rst_n, out_valid && out_kind == K_DONE, out_last, "done not last")
  `SNF_ASSERT_IMPL(a_kind, clk, rst_n, out_valid, out_kind != 2'd3, "bad kind")
  `SNF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

@@ sim/spi_nor_flash_command_sequencer_top_test.sv @@
// Self-checking testbench for the serial NOR flash command sequencer.
// Depends on snf_pkg and spi_nor_flash_command_sequencer_top; models the sequencer in-line.
`timescale 1ns / 1ps
module spi_nor_flash_command_sequencer_top_test;
  import snf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_func = '0;
  logic [25:0] in_address = '0;
  logic [15:0] in_length = '0;
  logic [7:0]  in_rx_byte = '0;
  logic [7:0]  in_payload_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic        out_end_of_frame;
  logic [1:0]  out_status;
  logic [63:0] out_info;
  logic        out_last;

  spi_nor_flash_command_sequencer_top i_dut (.*);

  // sequencer copy used for prediction
  phase_t      seq_phase;
  logic [7:0]  seq_opcode;
  logic [25:0] seq_addr;
  int unsigned seq_left;
  int unsigned seq_fidx;
  int unsigned seq_capacity;
  logic [7:0]  seq_devcode;
  logic [63:0] seq_uid;
  logic [7:0]  seq_mfr;

  res_t expected_results[$];
  int   mismatches = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   ops_started = 0;
  bit   idle_en = 1'b1;
  bit   hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  function automatic void push_result(logic [1:0] k, logic [7:0] v, logic e, logic [1:0] s,
                                      logic [63:0] inf);
    res_t r;
    r.kind = k; r.value = v; r.eof = e; r.status = s; r.info = inf; r.last = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void finish_op(logic [1:0] s, logic [7:0] v, logic [63:0] inf);
    push_result(K_DONE, v, 1'b0, s, inf);
    seq_phase = PH_IDLE;
    seq_fidx  = 0;
    seq_left  = 0;
  endfunction

  function automatic int unsigned hdr_len();
    if (seq_opcode == OP_READ) return 5;
    if (seq_opcode == OP_CE) return 1;
    return 4;
  endfunction

  function automatic bit carries_data();
    return seq_opcode == OP_READ || seq_opcode == OP_PROG;
  endfunction

  function automatic void tx_header(int unsigned idx);
    logic [7:0] b;
    case (idx)
      0: b = seq_opcode;
      1: b = seq_addr[23:16];
      2: b = seq_addr[15:8];
      3: b = seq_addr[7:0];
      default: b = 8'h00;
    endcase
    push_result(K_TX, b, (idx + 1 == hdr_len()) && !carries_data(), ST_OK, '0);
    seq_fidx = idx + 1;
  endfunction

  function automatic void tx_data(logic [7:0] pay);
    seq_left--;
    push_result(K_TX, (seq_opcode == OP_PROG) ? pay : 8'h00, seq_left == 0, ST_OK, '0);
  endfunction

  function automatic void begin_poll();
    seq_phase = PH_POLLC;
    push_result(K_TX, OP_RDSR, 1'b0, ST_OK, '0);
  endfunction

  function automatic void begin_wren(logic [7:0] opc, logic [25:0] a);
    seq_opcode = opc;
    seq_addr   = a;
    seq_phase  = PH_WREN;
    push_result(K_TX, OP_WREN, 1'b1, ST_OK, '0);
  endfunction

  function automatic void take_ack(logic [7:0] rx, logic [7:0] pay);
    int unsigned i;
    i = seq_fidx - 1;
    case (seq_phase)
      PH_ID: begin
        if (i == 4) seq_mfr = rx;
        if (i >= 5) begin
          seq_devcode = rx;
          if (seq_mfr != MFR_ID || rx < 8'h14 || rx > 8'h19) begin
            finish_op(ST_ID, seq_devcode, '0);
          end else begin
            seq_capacity = 32'h200000 << (rx - 8'h14);
            seq_opcode = OP_UID;
            seq_phase = PH_UID;
            seq_uid = '0;
            push_result(K_TX, OP_UID, 1'b0, ST_OK, '0);
            seq_fidx = 1;
          end
        end else begin
          push_result(K_TX, 8'h00, seq_fidx == 5, ST_OK, '0);
          seq_fidx++;
        end
      end
      PH_UID: begin
        if (i >= 5) seq_uid = {seq_uid[55:0], rx};
        if (i >= 12) begin
          finish_op(ST_OK, seq_devcode, seq_uid);
        end else begin
          push_result(K_TX, 8'h00, seq_fidx == 12, ST_OK, '0);
          seq_fidx++;
        end
      end
      PH_WREN: begin
        seq_phase = PH_CMD;
        tx_header(0);
      end
      PH_CMD: begin
        if (seq_fidx < hdr_len()) tx_header(seq_fidx);
        else if (carries_data()) begin
          seq_phase = PH_DATA;
          tx_data(pay);
        end else begin
          begin_poll();
        end
      end
      PH_DATA: begin
        if (seq_opcode == OP_READ) push_result(K_RD, rx, 1'b0, ST_OK, '0);
        if (seq_left > 0) tx_data(pay);
        else if (seq_opcode == OP_READ) finish_op(ST_OK, 8'h00, '0);
        else begin_poll();
      end
      PH_POLLC: begin
        seq_phase = PH_POLLD;
        push_result(K_TX, 8'h00, 1'b1, ST_OK, '0);
      end
      PH_POLLD: begin
        if (rx[0]) begin_poll();
        else finish_op(ST_OK, 8'h00, '0);
      end
      default: seq_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void predict_beat(logic [2:0] f, logic [25:0] a, logic [15:0] l,
                                       logic [7:0] rx, logic [7:0] pay);
    int n;
    int unsigned room;
    n = expected_results.size();
    if (f == FN_ACK || f == FN_LERR) begin
      if (seq_phase != PH_IDLE) begin
        if (f == FN_ACK) take_ack(rx, pay);
        else finish_op((seq_phase == PH_WREN) ? ST_REJ : ST_XFER, 8'h00, '0);
      end
    end else if (seq_phase == PH_IDLE) begin
      case (f)
        FN_INIT: begin
          seq_opcode = OP_ID;
          seq_phase = PH_ID;
          push_result(K_TX, OP_ID, 1'b0, ST_OK, '0);
          seq_fidx = 1;
        end
        FN_READ, FN_PROG: begin
          if (l == 0 || int'(a) + int'(l) > seq_capacity) begin
            finish_op(ST_REJ, 8'h00, '0);
          end else if (f == FN_READ) begin
            seq_opcode = OP_READ;
            seq_addr = a;
            seq_left = l;
            seq_phase = PH_CMD;
            tx_header(0);
          end else begin
            room = 256 - (a % 256);
            seq_left = (l > room) ? room : l;
            begin_wren(OP_PROG, a);
          end
        end
        FN_SE, FN_BE: begin
          if (a >= seq_capacity) finish_op(ST_REJ, 8'h00, '0);
          else if (f == FN_SE) begin_wren(OP_SE, {a[25:12], 12'h000});
          else begin_wren(OP_BE, {a[25:16], 16'h0000});
        end
        default: begin_wren(OP_CE, '0);
      endcase
    end
    if (expected_results.size() > n)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d value %02h", out_kind, out_value);
      end else begin
        e = expected_results.pop_front();
        if (out_kind !== e.kind || out_value !== e.value || out_end_of_frame !== e.eof ||
            out_status !== e.status || out_info !== e.info || out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d v%02h e%0d s%0d i%016h l%0d got k%0d v%02h e%0d s%0d i%016h l%0d",
                     e.kind, e.value, e.eof, e.status, e.info, e.last, out_kind, out_value,
                     out_end_of_frame, out_status, out_info, out_last);
        end
      end
    end
  end

  // result side flow control
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance with valid still high
  task automatic send_beat(logic [2:0] f, logic [25:0] a, logic [15:0] l, logic [7:0] rx,
                           logic [7:0] pay);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_address <= a;
    in_length <= l;
    in_rx_byte <= rx;
    in_payload_byte <= pay;
    do @(posedge clk); while (!in_ready);
    predict_beat(f, a, l, rx, pay);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] flash_reply();
    if (seq_phase == PH_ID && seq_fidx == 5)
      return ($urandom_range(0, 5) == 0) ? 8'($urandom) : MFR_ID;
    if (seq_phase == PH_ID && seq_fidx >= 6)
      return ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(8'h14, 8'h19));
    if (seq_phase == PH_POLLD)
      return {7'($urandom), $urandom_range(0, 2) == 0};
    return 8'($urandom);
  endfunction

  // drive acknowledgements until the operation ends; link errors and stray requests mixed in when noisy
  task automatic finish_sequence(bit noisy);
    while (seq_phase != PH_IDLE) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_beat(3'($urandom_range(0, 5)), 26'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
      else if (noisy && $urandom_range(0, 59) == 0)
        send_beat(FN_LERR, 26'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      else
        send_beat(FN_ACK, 26'($urandom), 16'($urandom), flash_reply(), 8'($urandom));
    end
  endtask

  task automatic run_op(logic [2:0] f, logic [25:0] a, logic [15:0] l, bit noisy);
    ops_started++;
    send_beat(f, a, l, 8'($urandom), 8'($urandom));
    finish_sequence(noisy);
  endtask

  // init with a chosen manufacturer and device code
  task automatic run_init(logic [7:0] mfr, logic [7:0] code);
    ops_started++;
    send_beat(FN_INIT, '0, '0, 8'h00, 8'h00);
    while (seq_phase != PH_IDLE) begin
      if (seq_phase == PH_ID && seq_fidx == 5)
        send_beat(FN_ACK, '0, '0, mfr, 8'($urandom));
      else if (seq_phase == PH_ID && seq_fidx >= 6)
        send_beat(FN_ACK, '0, '0, code, 8'($urandom));
      else
        send_beat(FN_ACK, '0, '0, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_reset_capacity();
    send_beat(FN_ACK, '1, '1, 8'hFF, 8'hFF);   // idle, ignored
    send_beat(FN_LERR, '0, '0, 8'h00, 8'h00);  // idle, ignored
    run_op(FN_READ, '0, 16'd1, 1'b0);
    run_op(FN_PROG, '0, 16'd1, 1'b0);
    run_op(FN_SE, '0, '0, 1'b0);
    run_op(FN_BE, '0, '0, 1'b0);
    run_op(FN_CE, '0, '0, 1'b0);
    // link error during write enable frame
    send_beat(FN_CE, '0, '0, 8'h00, 8'h00);
    send_beat(FN_LERR, '0, '0, 8'h00, 8'h00);
  endtask

  task automatic test_device_id();
    run_init(8'h00, 8'h17);
    run_init(MFR_ID, 8'h13);
    run_init(MFR_ID, 8'h1A);
    run_init(MFR_ID, 8'h14);
    run_op(FN_READ, 26'h1FFFFF, 16'd1, 1'b0);
    run_op(FN_READ, 26'h1FFFFF, 16'd2, 1'b0);
    run_init(MFR_ID, 8'h19);
  endtask

  task automatic test_operations();
    run_op(FN_READ, 26'h3FFFFFD, 16'd3, 1'b0);   // top of the largest part, high bits dropped
    run_op(FN_READ, 26'h0000100, 16'd0, 1'b0);   // zero length
    run_op(FN_READ, 26'h3FFFFFF, 16'hFFFF, 1'b0); // past the end
    run_op(FN_PROG, 26'h00012FE, 16'hFFFF, 1'b0); // clipped at the page end
    run_op(FN_PROG, 26'h2ABCD55, 16'd3, 1'b0);
    run_op(FN_SE, 26'h3FFFFFF, '0, 1'b0);
    run_op(FN_BE, 26'h1555555, '0, 1'b0);
    run_op(FN_CE, '0, '0, 1'b0);
    // request while busy is dropped, then a link error mid read
    send_beat(FN_READ, 26'h10, 16'd4, 8'h00, 8'h00);
    send_beat(FN_INIT, '0, '0, 8'h00, 8'h00);
    send_beat(FN_ACK, '0, '0, 8'hA5, 8'h5A);
    send_beat(FN_LERR, '0, '0, 8'h00, 8'h00);
  endtask

  task automatic random_op(bit noisy);
    logic [2:0]  f;
    logic [25:0] a;
    logic [15:0] l;
    f = ($urandom_range(0, 11) == 0) ? FN_INIT : 3'($urandom_range(1, 5));
    if (seq_capacity != 0 && $urandom_range(0, 7) != 0) a = 26'($urandom_range(0, seq_capacity - 1));
    else a = 26'($urandom);
    case ($urandom_range(0, 9))
      0: l = '0;
      1: l = 16'($urandom);
      default: l = 16'($urandom_range(1, 6));
    endcase
    if (f == FN_READ && l > 64 && int'(a) + int'(l) <= seq_capacity) l = {10'd0, l[5:0]} + 16'd1;
    run_op(f, a, l, noisy);
  endtask

  task automatic test_random_traffic();
    int target;
    target = beats_sent + 110;
    while (beats_sent < target) random_op(1'b1);
  endtask

  task automatic test_output_hold();
    int stop_at;
    hold_req = 1'b1;
    stop_at = beats_sent + 40;
    while (beats_sent < stop_at) random_op(1'b0);
  endtask

  task automatic test_pause_then_resume();
    wait_drained();
    repeat (3) random_op(1'b1);
  endtask

  task automatic test_no_idle_tail();
    int stop_at;
    idle_en = 1'b0;
    stop_at = beats_sent + 30;
    while (beats_sent < stop_at) random_op(1'b1);
  endtask

  initial begin
    int settle;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    seq_phase = PH_IDLE;
    seq_opcode = '0; seq_addr = '0; seq_left = 0; seq_fidx = 0;
    seq_capacity = 0; seq_devcode = '0; seq_uid = '0; seq_mfr = '0;
    @(negedge clk);

    test_reset_capacity();
    test_device_id();
    test_operations();
    test_random_traffic();
    test_output_hold();
    test_pause_then_resume();
    test_no_idle_tail();

    wait_drained();
    settle = 0;
    while (settle < 20) begin
      @(negedge clk);
      settle++;
    end
    $display("covered %0d operations in %0d input beats, %0d results checked",
             ops_started, beats_sent, results_seen);
    $display("init, read, program, erase, link errors, idle acks and busy requests exercised");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/snf_pkg.sv
rtl/snf_front.sv
rtl/snf_back.sv
rtl/spi_nor_flash_command_sequencer_top.sv
sim/spi_nor_flash_command_sequencer_top_test.sv
